// ===== rtl/drc_pkg.sv =====
package drc_pkg;

  // Fixed point format of all positions, directions and distances.
  localparam int FRAC_BITS = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;

  // Defaults for the top level parameters.
  localparam int MAP_DIM_DEF   = 64;
  localparam int MAX_STEPS_DEF = 128;

  // Field and register widths.
  localparam int POS_W   = 22;
  localparam int VEC_W   = 18;
  localparam int SCR_W   = 13;
  localparam int COL_W   = 12;
  localparam int CELL_W  = 6;
  localparam int PERP_W  = 24;
  localparam int STAT_W  = 2;
  localparam int CAM_W   = 31;
  localparam int RD_W    = 34;
  localparam int DELTA_W = 32;

  localparam logic [SCR_W-1:0] SCREEN_RESET = SCR_W'(640);

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = POS_W;
  localparam logic [REG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN  = 3'd6;

  // Request kinds carried on tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_HIT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_LEFT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

  // Input beat layout.
  localparam int IN_W     = 32;
  localparam int I_ROW    = 0;
  localparam int I_COL    = 6;
  localparam int I_WALL   = 12;
  localparam int I_COLUMN = 13;

  // Result beat layout.
  localparam int OUT_W  = 56;
  localparam int O_COL  = 0;
  localparam int O_PERP = 12;
  localparam int O_SIDE = 36;
  localparam int O_ROW  = 37;
  localparam int O_HCOL = 43;
  localparam int O_STAT = 49;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W = 1;
  localparam int QC_W = 2;

  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
    logic [SCR_W-1:0]        screen_width;
  } cfg_t;

  typedef struct packed {
    logic              req;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic              wall;
    logic [COL_W-1:0]  column;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [PERP_W-1:0] perp;
    logic              side;
    logic [CELL_W-1:0] hit_row;
    logic [CELL_W-1:0] hit_col;
    logic [STAT_W-1:0] status;
  } res_t;

  function automatic logic [RD_W-1:0] abs_rd(logic signed [RD_W-1:0] v);
    return v[RD_W-1] ? RD_W'(-v) : RD_W'(v);
  endfunction

endpackage

// ===== rtl/drc_ram.sv =====
module drc_ram import drc_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = MAP_DIM_DEF * MAP_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/drc_div.sv =====
module drc_div import drc_pkg::*; #(
  parameter int DVD_W = 42,
  parameter int DVS_W = RD_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, q_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[DVD_W-2:0], ge};
        rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/drc_front.sv =====
module drc_front import drc_pkg::*; #(
  parameter int MAP_DIM = MAP_DIM_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  input  logic            in_kind,
  input  back_ctl_t       ctl,
  output head_t           head
);

  item_t           item_in;
  logic            keep;
  logic            push;
  item_t           q_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wp_r;
  logic [QP_W-1:0] rp_r;
  logic [QC_W-1:0] cnt_r;

  // Unpack the beat and drop cell writes that fall outside the map.
  always_comb begin
    item_in.req    = in_kind;
    item_in.row    = in_data[I_ROW +: CELL_W];
    item_in.col    = in_data[I_COL +: CELL_W];
    item_in.wall   = in_data[I_WALL];
    item_in.column = in_data[I_COLUMN +: COL_W];
    keep = (item_in.req == REQ_CAST) ||
           ((int'(item_in.row) < MAP_DIM) && (int'(item_in.col) < MAP_DIM));
  end

  assign in_ready = !ctl.clearing && (cnt_r != QC_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;

  // Short queue toward the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QP_W'(1);
      end
      if (ctl.pop) begin
        rp_r <= rp_r + QP_W'(1);
      end
      if (push && !ctl.pop) begin
        cnt_r <= cnt_r + QC_W'(1);
      end else if (!push && ctl.pop) begin
        cnt_r <= cnt_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item_in;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rp_r];

endmodule

// ===== rtl/drc_back.sv =====
module drc_back import drc_pkg::*; #(
  parameter int MAP_DIM   = MAP_DIM_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  head_t     head,
  output back_ctl_t ctl,
  input  logic      out_ready,
  output logic      out_valid,
  output res_t      out_res
);

  localparam int IDX_W   = $clog2(MAP_DIM);
  localparam int IW      = (IDX_W > CELL_W) ? IDX_W : CELL_W;
  localparam int MW      = IW + 2;
  localparam int DEPTH   = MAP_DIM * MAP_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int SW      = DELTA_W + 2 + $clog2(MAX_STEPS);
  localparam int NW      = MW + FRAC_BITS + 2;
  localparam int DVD_W   = NW + FRAC_BITS;
  localparam int PROD_W  = VEC_W + CAM_W;
  localparam int SPROD_W = FRAC_BITS + 1 + DELTA_W;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_CAM    = 14'b00000000000100,
    S_MULX   = 14'b00000000001000,
    S_MULY   = 14'b00000000010000,
    S_DLX    = 14'b00000000100000,
    S_DLY    = 14'b00000001000000,
    S_SIDEX  = 14'b00000010000000,
    S_SIDEY  = 14'b00000100000000,
    S_STEP   = 14'b00001000000000,
    S_TEST   = 14'b00010000000000,
    S_PNUM   = 14'b00100000000000,
    S_PERP   = 14'b01000000000000,
    S_RESULT = 14'b10000000000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [AW-1:0]             clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]          col_r, col_nxt;
  logic signed [CAM_W-1:0]   cam_r, cam_nxt;
  logic signed [RD_W-1:0]    rdx_r, rdx_nxt, rdy_r, rdy_nxt;
  logic [DELTA_W-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SW-1:0]             sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [MW-1:0]      mx_r, mx_nxt, my_r, my_nxt;
  logic [STEP_W-1:0]         steps_r, steps_nxt;
  logic                      side_r, side_nxt;
  logic [STAT_W-1:0]         status_r, status_nxt;
  logic [PERP_W-1:0]         perp_r, perp_nxt;
  logic                      out_valid_r, out_valid_nxt;
  res_t                      out_r, out_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic                      ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic                      ram_rdata;

  logic                      div_start;
  logic [DVD_W-1:0]          div_dvd;
  logic [RD_W-1:0]           div_dvs;
  logic                      div_done;
  logic [DVD_W-1:0]          div_q;

  logic [SCR_W-1:0]          w_eff;
  logic                      mul_y;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RD_W-1:0]    ray_new;
  logic                      side_y;
  logic [FRAC_BITS:0]        fpart;
  logic [SPROD_W-1:0]        sprod;
  logic [DELTA_W-1:0]        delta_q;
  logic                      take_x;
  logic signed [MW-1:0]      nmx, nmy;
  logic                      off_map;
  logic                      start_out;
  logic signed [MW-1:0]      p_cell;
  logic                      p_neg;
  logic [POS_W-1:0]          p_pos;
  logic signed [RD_W-1:0]    p_rd;
  logic signed [NW-1:0]      p_cell_n;
  logic signed [NW-1:0]      p_num;
  logic [NW-1:0]             p_mag;

  drc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  drc_div #(.DVD_W(DVD_W), .DVS_W(RD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared multiplier for the ray direction: plane times camera factor.
  assign w_eff   = (cfg.screen_width == '0) ? SCR_W'(1) : cfg.screen_width;
  assign mul_y   = (state_r == S_MULY);
  assign prod    = PROD_W'(mul_y ? $signed(cfg.plane_y) : $signed(cfg.plane_x)) *
                   PROD_W'(cam_r);
  assign ray_new = RD_W'(mul_y ? $signed(cfg.dir_y) : $signed(cfg.dir_x)) +
                   RD_W'(prod >>> FRAC_BITS);

  // Shared multiplier for the first side distances.
  assign side_y = (state_r == S_SIDEY);
  always_comb begin
    logic [FRAC_BITS:0] frac;
    logic               neg;
    frac  = {1'b0, side_y ? cfg.pos_y[FRAC_BITS-1:0] : cfg.pos_x[FRAC_BITS-1:0]};
    neg   = side_y ? rdy_r[RD_W-1] : rdx_r[RD_W-1];
    fpart = neg ? frac : ((FRAC_BITS + 1)'(ONE_Q) - frac);
  end
  assign sprod = SPROD_W'(fpart) * SPROD_W'(side_y ? dy_r : dx_r);

  // Reciprocal delta with saturation.
  assign delta_q = (div_q[DVD_W-1:DELTA_W] != '0) ? '1 : div_q[DELTA_W-1:0];

  // One walk step: advance along the nearer side, ties go to y.
  assign take_x = (sx_r < sy_r);
  assign nmx = take_x ? mx_r + (rdx_r[RD_W-1] ? MW'(-1) : MW'(1)) : mx_r;
  assign nmy = take_x ? my_r : my_r + (rdy_r[RD_W-1] ? MW'(-1) : MW'(1));
  assign off_map = nmx[MW-1] || nmy[MW-1] ||
                   (nmx >= MW'(MAP_DIM)) || (nmy >= MW'(MAP_DIM));
  assign ram_raddr = AW'(nmx[IDX_W-1:0]) * AW'(MAP_DIM) + AW'(nmy[IDX_W-1:0]);

  assign start_out = (int'(cfg.pos_x[POS_W-1:FRAC_BITS]) >= MAP_DIM) ||
                     (int'(cfg.pos_y[POS_W-1:FRAC_BITS]) >= MAP_DIM);

  // Distance numerator on the side crossed last.
  assign p_cell   = side_r ? my_r : mx_r;
  assign p_rd     = side_r ? rdy_r : rdx_r;
  assign p_neg    = p_rd[RD_W-1];
  assign p_pos    = side_r ? cfg.pos_y : cfg.pos_x;
  assign p_cell_n = NW'(p_cell) + (p_neg ? NW'(1) : NW'(0));
  assign p_num    = (p_cell_n <<< FRAC_BITS) - NW'({1'b0, p_pos});
  assign p_mag    = p_num[NW-1] ? NW'(-p_num) : NW'(p_num);

  // Map writes come from the clearing sweep or from queued cell writes.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = 1'b0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if ((state_r == S_IDLE) && head.valid && (head.item.req == REQ_WRITE)) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(head.item.row) * AW'(MAP_DIM) + AW'(head.item.col);
      ram_wdata = head.item.wall;
    end
  end

  assign ctl.pop      = (state_r == S_IDLE) && head.valid;
  assign ctl.clearing = (state_r == S_CLEAR);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    col_nxt       = col_r;
    cam_nxt       = cam_r;
    rdx_nxt       = rdx_r;
    rdy_nxt       = rdy_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    steps_nxt     = steps_r;
    side_nxt      = side_r;
    status_nxt    = status_r;
    perp_nxt      = perp_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    div_start     = 1'b0;
    div_dvd       = DVD_W'(1) << (2 * FRAC_BITS);
    div_dvs       = abs_rd(rdx_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid && (head.item.req == REQ_CAST)) begin
          col_nxt   = head.item.column;
          div_start = 1'b1;
          div_dvd   = DVD_W'(head.item.column) << (FRAC_BITS + 1);
          div_dvs   = RD_W'(w_eff);
          state_nxt = S_CAM;
        end
      end
      S_CAM: begin
        if (div_done) begin
          cam_nxt   = $signed(div_q[CAM_W-1:0]) - CAM_W'(ONE_Q);
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        rdx_nxt   = ray_new;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        rdy_nxt   = ray_new;
        div_start = 1'b1;
        state_nxt = S_DLX;
      end
      S_DLX: begin
        if (div_done) begin
          dx_nxt    = (rdx_r == '0) ? '1 : delta_q;
          div_start = 1'b1;
          div_dvs   = abs_rd(rdy_r);
          state_nxt = S_DLY;
        end
      end
      S_DLY: begin
        if (div_done) begin
          dy_nxt    = (rdy_r == '0) ? '1 : delta_q;
          state_nxt = S_SIDEX;
        end
      end
      S_SIDEX: begin
        sx_nxt    = SW'(sprod >> FRAC_BITS);
        mx_nxt    = MW'(cfg.pos_x[POS_W-1:FRAC_BITS]);
        my_nxt    = MW'(cfg.pos_y[POS_W-1:FRAC_BITS]);
        state_nxt = S_SIDEY;
      end
      S_SIDEY: begin
        sy_nxt    = SW'(sprod >> FRAC_BITS);
        steps_nxt = '0;
        side_nxt  = 1'b0;
        if (start_out) begin
          status_nxt = ST_LEFT;
          perp_nxt   = '0;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        mx_nxt    = nmx;
        my_nxt    = nmy;
        side_nxt  = !take_x;
        steps_nxt = steps_r + STEP_W'(1);
        if (take_x) begin
          sx_nxt = sx_r + SW'(dx_r);
        end else begin
          sy_nxt = sy_r + SW'(dy_r);
        end
        if (off_map) begin
          status_nxt = ST_LEFT;
          state_nxt  = S_PNUM;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (ram_rdata) begin
          status_nxt = ST_HIT;
          state_nxt  = S_PNUM;
        end else if (steps_r == STEP_W'(MAX_STEPS)) begin
          status_nxt = ST_LIMIT;
          state_nxt  = S_PNUM;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_PNUM: begin
        if (p_rd == '0) begin
          perp_nxt  = '1;
          state_nxt = S_RESULT;
        end else if ((p_num == '0) || (p_num[NW-1] != p_neg)) begin
          perp_nxt  = '0;
          state_nxt = S_RESULT;
        end else begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(p_mag) << FRAC_BITS;
          div_dvs   = abs_rd(p_rd);
          state_nxt = S_PERP;
        end
      end
      S_PERP: begin
        if (div_done) begin
          perp_nxt  = (div_q[DVD_W-1:PERP_W] != '0) ? '1 : div_q[PERP_W-1:0];
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.column  = col_r;
          out_nxt.perp    = perp_r;
          out_nxt.side    = side_r;
          out_nxt.hit_row = mx_r[CELL_W-1:0];
          out_nxt.hit_col = my_r[CELL_W-1:0];
          out_nxt.status  = status_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    cam_r    <= cam_nxt;
    rdx_r    <= rdx_nxt;
    rdy_r    <= rdy_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    steps_r  <= steps_nxt;
    side_r   <= side_nxt;
    status_r <= status_nxt;
    perp_r   <= perp_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== rtl/dda_grid_raycaster_unit.sv =====
// Grid ray caster. Beats with tuser 0 write one wall map cell and give no
// result; beats with tuser 1 cast the ray for one screen column and give one
// result beat. After reset the map is swept to open, one cell a cycle, and
// in_tready stays low during the sweep; configuration writes are taken at any
// time. A cell write is done by the back end in its idle state. In a cast the
// four divisions (camera factor, two reciprocal deltas, wall distance) run one
// quotient bit a cycle on a single shared divider with DVD_W =
// clog2(MAP_DIM)+36 bits at least (42 by default), and every DDA step passes
// through a step state and a test state for the map read. A two-beat queue
// separates input from the back end and a result register separates the back
// end from the output.
module dda_grid_raycaster_unit import drc_pkg::*; #(
  parameter int MAP_DIM   = MAP_DIM_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_row, cell_col, cell_wall, column, zero fill
  input  logic [IN_W-1:0]       in_tdata,
  // req_type
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_column, perp_dist, wall_side, hit_row, hit_col, status, zero fill
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  head_t     head;
  back_ctl_t ctl;
  res_t      res;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x        <= '0;
      cfg_r.pos_y        <= '0;
      cfg_r.dir_x        <= '0;
      cfg_r.dir_y        <= '0;
      cfg_r.plane_x      <= '0;
      cfg_r.plane_y      <= '0;
      cfg_r.screen_width <= SCREEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POS_X:   cfg_r.pos_x        <= cfg_data[POS_W-1:0];
        REG_POS_Y:   cfg_r.pos_y        <= cfg_data[POS_W-1:0];
        REG_DIR_X:   cfg_r.dir_x        <= $signed(cfg_data[VEC_W-1:0]);
        REG_DIR_Y:   cfg_r.dir_y        <= $signed(cfg_data[VEC_W-1:0]);
        REG_PLANE_X: cfg_r.plane_x      <= $signed(cfg_data[VEC_W-1:0]);
        REG_PLANE_Y: cfg_r.plane_y      <= $signed(cfg_data[VEC_W-1:0]);
        REG_SCREEN:  cfg_r.screen_width <= cfg_data[SCR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  drc_front #(.MAP_DIM(MAP_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .in_kind  (in_tuser),
    .ctl      (ctl),
    .head     (head)
  );

  drc_back #(.MAP_DIM(MAP_DIM), .MAX_STEPS(MAX_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .ctl       (ctl),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  // Pack the result beat.
  always_comb begin
    out_tdata                      = '0;
    out_tdata[O_COL  +: COL_W]     = res.column;
    out_tdata[O_PERP +: PERP_W]    = res.perp;
    out_tdata[O_SIDE]              = res.side;
    out_tdata[O_ROW  +: CELL_W]    = res.hit_row;
    out_tdata[O_HCOL +: CELL_W]    = res.hit_col;
    out_tdata[O_STAT +: STAT_W]    = res.status;
  end

endmodule

// ===== rtl/drc_checker.sv =====
module drc_checker import drc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [7:0] pend_r;
  logic       cast_in;
  logic       res_out;

  // Casts accepted whose result beat has not yet been taken.
  assign cast_in = in_tvalid && in_tready && (in_tuser == REQ_CAST);
  assign res_out = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(cast_in) - 8'(res_out);
    end
  end

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn before it was taken");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result beat changed");

  // Every result beat belongs to an accepted cast.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != '0)
    else $error("result beat without a pending cast");

  // The status field carries a defined code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[O_STAT +: STAT_W] == ST_HIT) ||
                   (out_tdata[O_STAT +: STAT_W] == ST_LEFT) ||
                   (out_tdata[O_STAT +: STAT_W] == ST_LIMIT))
    else $error("undefined status code");

endmodule

bind dda_grid_raycaster_unit drc_checker u_drc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import drc_pkg::*;

  localparam int            CELLS       = 64;
  localparam int            STEP_LIMIT  = 128;
  localparam longint        ONE         = 64'sd1 << FRAC_BITS;
  localparam longint        DELTA_SAT   = 64'hFFFF_FFFF;
  localparam longint        PERP_SAT    = 64'hFF_FFFF;
  localparam int            SETTLE      = 40;
  localparam longint        CYCLE_LIMIT = 3_000_000;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} row_kind_t;

  // One row of the directed stimulus table.
  typedef struct {
    row_kind_t            kind;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic                 req;
    logic [CELL_W-1:0]    row;
    logic [CELL_W-1:0]    col;
    logic                 wall;
    logic [COL_W-1:0]     column;
    bit                   typed;
    res_t                 res;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's registers and wall map.
  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [SCR_W-1:0]        scr_width;
  bit                      wall_map [CELLS*CELLS];

  res_t   pending_hits [$];
  int     errors = 0;
  bit     in_idle = 1'b1;
  bit     out_idle = 1'b1;
  longint cycles = 0;
  step_t  plan [$];

  always #5 clk = ~clk;

  dda_grid_raycaster_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned inv_delta(longint rd);
    longint unsigned q;
    if (rd == 0) return DELTA_SAT;
    q = (64'd1 << (2 * FRAC_BITS)) / magnitude(rd);
    return q > DELTA_SAT ? DELTA_SAT : q;
  endfunction

  function automatic longint unsigned wall_distance(longint cell_idx, longint stp, longint p,
                                                    longint rd);
    longint          num;
    longint unsigned q;
    num = (cell_idx + (stp < 0 ? 1 : 0)) * ONE - p;
    if (rd == 0) return PERP_SAT;
    if (num == 0 || ((num < 0) != (rd < 0))) return 0;
    q = (magnitude(num) << FRAC_BITS) / magnitude(rd);
    return q > PERP_SAT ? PERP_SAT : q;
  endfunction

  // Cast one screen column through the shadow map.
  function automatic res_t cast_column(logic [COL_W-1:0] column);
    res_t            r;
    longint          w, cam, rdx, rdy, mx, my, stx, sty, px, py;
    longint unsigned dx, dy, fx, fy, sx, sy, perp;
    logic [STAT_W-1:0] st;
    logic            side;
    w    = (scr_width == 0) ? 1 : longint'(scr_width);
    px   = longint'(pos_x);
    py   = longint'(pos_y);
    cam  = ((longint'(column) * 2) << FRAC_BITS) / w - ONE;
    rdx  = longint'(dir_x) + ((longint'(plane_x) * cam) >>> FRAC_BITS);
    rdy  = longint'(dir_y) + ((longint'(plane_y) * cam) >>> FRAC_BITS);
    mx   = px >>> FRAC_BITS;
    my   = py >>> FRAC_BITS;
    dx   = inv_delta(rdx);
    dy   = inv_delta(rdy);
    fx   = px & (ONE - 1);
    fy   = py & (ONE - 1);
    stx  = rdx < 0 ? -1 : 1;
    sty  = rdy < 0 ? -1 : 1;
    sx   = ((rdx < 0 ? fx : ONE - fx) * dx) >> FRAC_BITS;
    sy   = ((rdy < 0 ? fy : ONE - fy) * dy) >> FRAC_BITS;
    st   = ST_LIMIT;
    side = 1'b0;
    perp = 0;
    if (mx >= CELLS || my >= CELLS) begin
      st = ST_LEFT;
    end else begin
      for (int i = 0; i < STEP_LIMIT; i++) begin
        if (sx < sy) begin
          sx += dx;
          mx += stx;
          side = 1'b0;
        end else begin
          sy += dy;
          my += sty;
          side = 1'b1;
        end
        if (mx < 0 || my < 0 || mx >= CELLS || my >= CELLS) begin
          st = ST_LEFT;
          break;
        end
        if (wall_map[mx * CELLS + my]) begin
          st = ST_HIT;
          break;
        end
      end
      perp = side ? wall_distance(my, sty, py, rdy) : wall_distance(mx, stx, px, rdx);
    end
    r.column  = column;
    r.perp    = perp[PERP_W-1:0];
    r.side    = side;
    r.hit_row = mx[CELL_W-1:0];
    r.hit_col = my[CELL_W-1:0];
    r.status  = st;
    return r;
  endfunction

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side back pressure, in random bursts.
  initial begin
    while (1) begin
      @(negedge clk);
      if (out_idle && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // Compare every result beat with the oldest expected result.
  always @(posedge clk) begin
    res_t got, want;
    if (out_tvalid && out_tready) begin
      got.column  = out_tdata[O_COL  +: COL_W];
      got.perp    = out_tdata[O_PERP +: PERP_W];
      got.side    = out_tdata[O_SIDE];
      got.hit_row = out_tdata[O_ROW  +: CELL_W];
      got.hit_col = out_tdata[O_HCOL +: CELL_W];
      got.status  = out_tdata[O_STAT +: STAT_W];
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: expected no result beat, actual %h", $time, out_tdata);
      end else begin
        want = pending_hits.pop_front();
        if (got.column !== want.column || got.perp !== want.perp ||
            got.side !== want.side || got.hit_row !== want.hit_row ||
            got.hit_col !== want.hit_col || got.status !== want.status) begin
          errors++;
          $display("%0t: expected col %0d perp %h side %0d cell %0d,%0d status %0d",
                   $time, want.column, want.perp, want.side, want.hit_row,
                   want.hit_col, want.status);
          $display("%0t: actual   col %0d perp %h side %0d cell %0d,%0d status %0d",
                   $time, got.column, got.perp, got.side, got.hit_row,
                   got.hit_col, got.status);
        end
      end
    end
  end

  // Wait until every cast has answered and any trailing cell write is done.
  task automatic drain();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POS_X:   pos_x     = data[POS_W-1:0];
      REG_POS_Y:   pos_y     = data[POS_W-1:0];
      REG_DIR_X:   dir_x     = data[VEC_W-1:0];
      REG_DIR_Y:   dir_y     = data[VEC_W-1:0];
      REG_PLANE_X: plane_x   = data[VEC_W-1:0];
      REG_PLANE_Y: plane_y   = data[VEC_W-1:0];
      REG_SCREEN:  scr_width = data[SCR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send one request beat; the expected result is formed at acceptance.
  task automatic send_request(logic req, logic [CELL_W-1:0] row, logic [CELL_W-1:0] col,
                              logic wall, logic [COL_W-1:0] column, bit typed, res_t res);
    @(negedge clk);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {7'b0, column, wall, col, row};
    do @(posedge clk); while (!in_tready);
    if (req == REQ_WRITE) wall_map[row * CELLS + col] = wall;
    else pending_hits.push_back(typed ? res : cast_column(column));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic void add_cfg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '{kind: ROW_CFG, idx: idx, data: data, default: '0};
    plan.push_back(s);
  endfunction

  function automatic void add_item(logic req, int row, int col, logic wall, int column,
                                   bit typed = 0, res_t res = '0);
    step_t s;
    s = '{kind: ROW_ITEM, req: req, row: CELL_W'(row), col: CELL_W'(col), wall: wall,
          column: COL_W'(column), typed: typed, res: res, default: '0};
    plan.push_back(s);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_vec();
    int v;
    if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 262143) - 131072;
    else v = $urandom_range(0, 131072) - 65536;
    return CFG_DATA_W'(v);
  endfunction

  initial begin
    res_t blank;
    pos_x = '0; pos_y = '0; dir_x = '0; dir_y = '0; plane_x = '0; plane_y = '0;
    scr_width = SCREEN_RESET;
    foreach (wall_map[i]) wall_map[i] = 1'b0;

    // A zero ray walks the diagonal staircase and leaves at the far y edge.
    add_item(REQ_CAST, 0, 0, 0, 0, 1, '{12'd0, 24'hFF_FFFF, 1'b1, 6'd63, 6'd0, ST_LEFT});
    add_item(REQ_CAST, 0, 0, 0, 4095, 1,
             '{12'd4095, 24'hFF_FFFF, 1'b1, 6'd63, 6'd0, ST_LEFT});
    // Looking along +x from the map center with a wall in the way.
    add_cfg(REG_POS_X, 22'h20_8000);
    add_cfg(REG_POS_Y, 22'h20_8000);
    add_cfg(REG_DIR_X, 22'h1_0000);
    add_cfg(REG_DIR_Y, 22'h0);
    add_cfg(REG_PLANE_X, 22'h0);
    add_cfg(REG_PLANE_Y, 22'hA8F5);
    add_cfg(REG_SCREEN, 22'd64);
    add_item(REQ_WRITE, 40, 32, 1, 0);
    add_item(REQ_WRITE, 63, 63, 1, 0);
    add_item(REQ_CAST, 0, 0, 0, 32);
    add_item(REQ_CAST, 0, 0, 0, 0);
    add_item(REQ_CAST, 0, 0, 0, 63);
    add_item(REQ_WRITE, 40, 32, 0, 0);
    add_item(REQ_CAST, 0, 0, 0, 32);
    add_item(REQ_CAST, 0, 0, 0, 4095);
    // Extreme vectors, the far corner and a zero width.
    add_cfg(REG_POS_X, 22'h3F_FFFF);
    add_cfg(REG_POS_Y, 22'h3F_FFFF);
    add_cfg(REG_DIR_X, 22'h3_FFFF & 22'h2_0000);
    add_cfg(REG_DIR_Y, 22'h1_FFFF);
    add_cfg(REG_PLANE_X, 22'h1_FFFF);
    add_cfg(REG_PLANE_Y, 22'h2_0000);
    add_cfg(REG_SCREEN, 22'd0);
    add_item(REQ_CAST, 0, 0, 0, 0);
    add_item(REQ_CAST, 0, 0, 0, 1);
    add_item(REQ_WRITE, 0, 0, 1, 0);
    add_cfg(REG_POS_X, 22'h0);
    add_cfg(REG_POS_Y, 22'h0);
    add_cfg(REG_SCREEN, 22'd4096);
    add_item(REQ_CAST, 0, 0, 0, 0);
    add_item(REQ_CAST, 0, 0, 0, 2048);
    add_item(REQ_CAST, 0, 0, 0, 4095);
    add_item(REQ_WRITE, 0, 0, 0, 0);
    add_item(REQ_WRITE, 63, 63, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_request(plan[i].req, plan[i].row, plan[i].col, plan[i].wall,
                     plan[i].column, plan[i].typed, plan[i].res);
      end
    end

    // Random phases, each with fresh settings; the last runs without idling.
    for (int ph = 0; ph < 10; ph++) begin
      int wall_pct;
      drain();
      if (ph == 9) begin
        in_idle  = 1'b0;
        out_idle = 1'b0;
      end
      write_reg(REG_POS_X, CFG_DATA_W'($urandom_range(0, 4194303)));
      write_reg(REG_POS_Y, CFG_DATA_W'($urandom_range(0, 4194303)));
      write_reg(REG_DIR_X, rand_vec());
      write_reg(REG_DIR_Y, rand_vec());
      write_reg(REG_PLANE_X, rand_vec());
      write_reg(REG_PLANE_Y, rand_vec());
      case ($urandom_range(0, 5))
        0:       write_reg(REG_SCREEN, CFG_DATA_W'($urandom_range(1, 8)));
        1:       write_reg(REG_SCREEN, CFG_DATA_W'($urandom_range(0, 8191)));
        default: write_reg(REG_SCREEN, CFG_DATA_W'($urandom_range(16, 4096)));
      endcase
      wall_pct = $urandom_range(30, 90);
      for (int n = 0; n < 55; n++) begin
        blank = '0;
        if ($urandom_range(0, 99) < 50)
          send_request(REQ_WRITE, CELL_W'($urandom_range(0, 63)),
                       CELL_W'($urandom_range(0, 63)),
                       $urandom_range(0, 99) < wall_pct,
                       COL_W'($urandom_range(0, 4095)), 0, blank);
        else if ($urandom_range(0, 3) == 0)
          send_request(REQ_CAST, CELL_W'($urandom_range(0, 63)),
                       CELL_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                       COL_W'($urandom_range(0, 4095)), 0, blank);
        else
          send_request(REQ_CAST, CELL_W'($urandom_range(0, 63)),
                       CELL_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                       COL_W'($urandom_range(0, scr_width > 0 ? scr_width - 1 : 0)),
                       0, blank);
      end
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/drc_pkg.sv
rtl/drc_ram.sv
rtl/drc_div.sv
rtl/drc_front.sv
rtl/drc_back.sv
rtl/dda_grid_raycaster_unit.sv
rtl/drc_checker.sv
dv/testbench.sv
